// File: rtl/core/dmwt_pkg.sv
// Shared constants, payload types and defaults of the direct-mapped write-through tag controller.
package dmwt_pkg;

	localparam int DMWT_LINE_COUNT  = 128;
	localparam int DMWT_OFFSET_BITS = 5;

	localparam int ADDR_W    = 32;
	localparam int OFFSET_W  = 5;
	localparam int BLOCK_W   = 27;
	localparam int LINE_W    = 7;
	localparam int TAG_W     = 20;
	localparam int BYTES_W   = 6;
	localparam int COUNT_W   = 31;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic              is_write;
	} dmwt_req_t;

	// Classified access, as handed from the front to the back
	typedef struct packed {
		logic                is_write;
		logic [OFFSET_W-1:0] byte_offset;
		logic [BLOCK_W-1:0]  block_number;
		logic [TAG_W-1:0]    tag_value;
	} dmwt_item_t;

	localparam int ITEM_W = $bits(dmwt_item_t);

	typedef struct packed {
		logic [OFFSET_W-1:0] byte_offset;
		logic [BLOCK_W-1:0]  block_number;
		logic [LINE_W-1:0]   line_index;
		logic [TAG_W-1:0]    tag_value;
		logic                miss;
		logic                mem_read;
		logic                mem_write;
		logic [BYTES_W-1:0]  mem_bytes;
		logic                replaced;
		logic [TAG_W-1:0]    evicted_tag;
		logic [COUNT_W-1:0]  hit_total;
		logic [COUNT_W-1:0]  miss_total;
	} dmwt_rsp_t;

endpackage

// File: rtl/core/dmwt_stream_if.sv
// Valid/ready channel carrying one payload per transaction.
interface dmwt_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/direct_mapped_write_through_tags.sv
// Path: an accepted access passes the front stages s1, s2 and s3, the two-entry queue,
// then the tag RAM read (ST_LOOK) and the registered result update in the back end.
// The back end takes a new access only in ST_IDLE, so not while it reads and updates the last one.
// The front accepts one access per cycle until the two-entry queue fills.
// Reset: asynchronous, active low; clears counters and control state, then a clearing
// pass zeroes every tag RAM entry while req.ready stays low.
module direct_mapped_write_through_tags #(
	parameter int LINE_COUNT  = dmwt_pkg::DMWT_LINE_COUNT,
	parameter int OFFSET_BITS = dmwt_pkg::DMWT_OFFSET_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	dmwt_stream_if.sink   req,
	dmwt_stream_if.source rsp
);
	import dmwt_pkg::*;

	localparam int IDX_W = $clog2(LINE_COUNT);
	localparam int Q_W   = ITEM_W + IDX_W;

	// Front to queue: a classified access plus its line index
	logic             fq_valid, fq_ready;
	dmwt_item_t       fq_item;
	logic [IDX_W-1:0] fq_line;

	// Queue to back
	logic             qb_valid, qb_ready;
	logic [Q_W-1:0]   qb_data;
	dmwt_item_t       qb_item;
	logic [IDX_W-1:0] qb_line;

	// Hold off new accesses until the tag RAM sweep after reset is done
	logic             clear_done;

	dmwt_front #(
		.LINE_COUNT  (LINE_COUNT),
		.OFFSET_BITS (OFFSET_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.enable    (clear_done),
		.req       (req),
		.out_valid (fq_valid),
		.out_ready (fq_ready),
		.out_item  (fq_item),
		.out_line  (fq_line)
	);

	// Decouple classification from lookup so each side stalls on its own
	dmwt_queue #(
		.WIDTH (Q_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_data   ({fq_item, fq_line}),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_data  (qb_data)
	);

	assign qb_item = qb_data[Q_W-1:IDX_W];
	assign qb_line = qb_data[IDX_W-1:0];

	// Look up the tag, fill on a read miss, count, and register the result transaction
	dmwt_back #(
		.LINE_COUNT  (LINE_COUNT),
		.OFFSET_BITS (OFFSET_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear_done (clear_done),
		.in_valid   (qb_valid),
		.in_ready   (qb_ready),
		.in_item    (qb_item),
		.in_line    (qb_line),
		.rsp        (rsp)
	);
endmodule

// File: rtl/core/dmwt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dmwt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// File: rtl/core/dmwt_front.sv
// Front end: accept accesses, split the address and compute the line index.
module dmwt_front #(
	parameter int LINE_COUNT  = 128,
	parameter int OFFSET_BITS = 5,
	localparam int IDX_W = $clog2(LINE_COUNT)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   enable,
	dmwt_stream_if.sink            req,
	output logic                   out_valid,
	input  logic                   out_ready,
	output dmwt_pkg::dmwt_item_t   out_item,
	output logic [IDX_W-1:0]       out_line
);
	import dmwt_pkg::*;

	localparam int BLK_W  = ADDR_W - OFFSET_BITS;
	localparam int RSHIFT = BLK_W + IDX_W;
	localparam int RCP_W  = BLK_W + 1;
	localparam int PROD_W = BLK_W + RCP_W;
	localparam int REM_W  = IDX_W + 1;
	localparam int TSHIFT = OFFSET_BITS + IDX_W;
	localparam logic [RCP_W-1:0]  RECIP  = RCP_W'((64'd1 << RSHIFT) / LINE_COUNT);
	localparam logic [REM_W-1:0]  LC_REM = REM_W'(LINE_COUNT);
	localparam logic [ADDR_W-1:0] OFF_MASK = ADDR_W'((64'd1 << OFFSET_BITS) - 64'd1);

	logic              valid_s1, valid_s2, valid_s3;
	logic              adv;
	logic [ADDR_W-1:0] addr_s1;
	logic              wr_s1;
	logic [BLK_W-1:0]  block_s1;
	logic [PROD_W-1:0] prod;
	dmwt_item_t        item_s1, item_s2, item_s3;
	logic [REM_W-1:0]  blk_lo_s2, quot_s2, rem_s3;

	// Stall the whole front when its last stage cannot drain into the queue
	assign adv       = !valid_s3 || out_ready;
	assign req.ready = adv && enable;

	assign block_s1 = BLK_W'(addr_s1 >> OFFSET_BITS);
	assign prod     = PROD_W'(block_s1) * PROD_W'(RECIP);

	always_comb begin
		item_s1.is_write     = wr_s1;
		item_s1.byte_offset  = OFFSET_W'(addr_s1 & OFF_MASK);
		item_s1.block_number = BLOCK_W'(block_s1);
		item_s1.tag_value    = TAG_W'(addr_s1 >> TSHIFT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= req.valid && req.ready;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			addr_s1   <= req.data.address;
			wr_s1     <= req.data.is_write;
			item_s2   <= item_s1;
			blk_lo_s2 <= REM_W'(block_s1);
			// quotient estimate, low or exact by one
			quot_s2   <= REM_W'(prod >> RSHIFT);
			item_s3   <= item_s2;
			// remainder below twice the line count; only the low bits matter
			rem_s3    <= blk_lo_s2 - REM_W'(quot_s2 * LC_REM);
		end
	end

	assign out_valid = valid_s3;
	assign out_item  = item_s3;
	assign out_line  = IDX_W'((rem_s3 >= LC_REM) ? (rem_s3 - LC_REM) : rem_s3);
endmodule

// File: rtl/core/dmwt_queue.sv
// Two-entry queue decoupling the front from the back.
module dmwt_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);
	import dmwt_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	assign in_ready  = count_q != CNT_W'(QUEUE_DEPTH);
	assign out_valid = count_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_data  = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= in_data;
		end
	end
endmodule

// File: rtl/core/dmwt_back.sv
// Back end: tag lookup, line fill, counters and the registered result.
module dmwt_back #(
	parameter int LINE_COUNT  = 128,
	parameter int OFFSET_BITS = 5,
	localparam int IDX_W = $clog2(LINE_COUNT)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	output logic                 clear_done,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  dmwt_pkg::dmwt_item_t in_item,
	input  logic [IDX_W-1:0]     in_line,
	dmwt_stream_if.source        rsp
);
	import dmwt_pkg::*;

	localparam int ENTRY_W = TAG_W + 1;
	localparam logic [BYTES_W-1:0] FILL_BYTES = BYTES_W'(64'd1 << OFFSET_BITS);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK
	} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   clr_q;
	dmwt_item_t         item_q;
	logic [IDX_W-1:0]   line_q;
	logic [COUNT_W-1:0] hit_q, miss_q;
	logic               rsp_valid_q;
	dmwt_rsp_t          rsp_q;

	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
	logic               ram_re;
	logic               line_valid;
	logic [TAG_W-1:0]   line_tag;
	logic               hit, fill, commit;
	logic [COUNT_W-1:0] hit_next, miss_next;

	assign in_ready   = state_q == ST_IDLE;
	assign ram_re     = in_valid && in_ready;
	assign clear_done = state_q != ST_CLEAR;

	assign line_valid = ram_rdata[ENTRY_W-1];
	assign line_tag   = ram_rdata[TAG_W-1:0];
	assign hit        = line_valid && (line_tag == item_q.tag_value);
	assign fill       = !hit && !item_q.is_write;
	assign commit     = (state_q == ST_LOOK) && (!rsp_valid_q || rsp.ready);
	assign hit_next   = (hit && hit_q != COUNT_MAX) ? hit_q + 1'b1 : hit_q;
	assign miss_next  = (!hit && miss_q != COUNT_MAX) ? miss_q + 1'b1 : miss_q;

	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = commit && fill;
			ram_waddr = line_q;
			ram_wdata = {1'b1, item_q.tag_value};
		end
	end

	dmwt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (LINE_COUNT)
	) u_tag_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (in_line),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			hit_q       <= '0;
			miss_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(LINE_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (commit) begin
						hit_q       <= hit_next;
						miss_q      <= miss_next;
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			item_q <= in_item;
			line_q <= in_line;
		end
		if (commit) begin
			rsp_q.byte_offset  <= item_q.byte_offset;
			rsp_q.block_number <= item_q.block_number;
			rsp_q.line_index   <= LINE_W'(line_q);
			rsp_q.tag_value    <= item_q.tag_value;
			rsp_q.miss         <= !hit;
			rsp_q.mem_read     <= fill;
			rsp_q.mem_write    <= item_q.is_write;
			rsp_q.mem_bytes    <= item_q.is_write ? BYTES_W'(1) : (fill ? FILL_BYTES : '0);
			rsp_q.replaced     <= fill && line_valid;
			rsp_q.evicted_tag  <= (fill && line_valid) ? line_tag : '0;
			rsp_q.hit_total    <= hit_next;
			rsp_q.miss_total   <= miss_next;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;
endmodule

// File: rtl/core/dmwt_checker.sv
// Port-level checks on the result channel, bound to the top level.
module dmwt_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input dmwt_pkg::dmwt_rsp_t rsp_data
);
	import dmwt_pkg::*;

	// A stalled result transaction holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");

	// A write moves exactly one byte and never fills or evicts
	a_write_through: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.mem_write |->
			rsp_data.mem_bytes == BYTES_W'(1) && !rsp_data.mem_read && !rsp_data.replaced)
		else $error("write did not go through as one byte");

	// An eviction only follows a read miss, with a tag other than the access's
	a_replace: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.replaced |->
			rsp_data.miss && rsp_data.mem_read &&
			rsp_data.evicted_tag != rsp_data.tag_value)
		else $error("bad replacement");

	// A hit touches no line and reports no eviction
	a_hit_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.miss |->
			!rsp_data.mem_read && rsp_data.evicted_tag == '0)
		else $error("hit caused a fill or eviction");
endmodule

bind direct_mapped_write_through_tags dmwt_checker u_dmwt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
